// File: hw/rtl/ust_pkg.sv
package ust_pkg;

  localparam int CAPACITY       = 64;
  localparam int ELEMENT_BITS   = 32;
  localparam int INPUT_BITS     = 32;
  localparam int COUNT_OUT_BITS = 7;
  localparam int IDX_BITS       = $clog2(CAPACITY);
  localparam int COUNT_BITS     = $clog2(CAPACITY + 1);

  localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

  typedef logic [ELEMENT_BITS-1:0] elem_t;
  typedef logic [COUNT_BITS-1:0]   count_t;
  typedef logic [IDX_BITS-1:0]     idx_t;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_NO_CHANGE = 2'd1,
    STAT_REJECTED  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic  load;
    logic  clear;
    logic  scan_step;
    logic  append;
    logic  shift_start;
    logic  shift_step;
    logic  drop;
    logic  res_load;
    logic  res_was;
    stat_t res_status;
    logic  emit;
  } ust_cmd_t;

  typedef struct packed {
    op_t  in_op;
    op_t  op;
    logic scan_done;
    logic hit;
    logic full;
    logic shift_done;
    logic out_free;
  } ust_stat_t;

  // sign-extend the raw field, then keep the element width
  function automatic elem_t normalize(logic [INPUT_BITS-1:0] raw);
    logic [63:0] ext;
    ext = {{(64-INPUT_BITS){raw[INPUT_BITS-1]}}, raw};
    return ext[ELEMENT_BITS-1:0];
  endfunction

endpackage

// File: hw/rtl/ust_req_if.sv
interface ust_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] element;

  modport source (output valid, output opcode, output element, input ready);
  modport sink (input valid, input opcode, input element, output ready);
endinterface

// File: hw/rtl/ust_rsp_if.sv
interface ust_rsp_if;
  logic       valid;
  logic       ready;
  logic       was_member;
  logic [6:0] count_after;
  logic       is_empty;
  logic       is_full;
  logic [1:0] status;

  modport source (output valid, output was_member, output count_after, output is_empty,
                  output is_full, output status, input ready);
  modport sink (input valid, input was_member, input count_after, input is_empty,
                input is_full, input status, output ready);
endinterface

// File: hw/rtl/ust_ram.sv
module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ust_datapath.sv
module ust_datapath import ust_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      opcode,
  input  logic [31:0]     element,
  input  ust_cmd_t        cmd,
  output ust_stat_t       st,
  ust_rsp_if.source       rsp
);

  op_t    op_q;
  elem_t  val_q;
  count_t count;
  count_t scan_idx;
  logic   chk_valid;
  idx_t   chk_idx;
  count_t sh_idx;
  logic   sh_pend;
  idx_t   sh_wr;
  logic   res_was;
  stat_t  res_status;
  logic   out_valid;

  logic   hit;
  logic   issue_scan;
  logic   issue_shift;
  logic   wr_en;
  idx_t   wr_addr;
  elem_t  wr_data;
  logic   rd_en;
  idx_t   rd_addr;
  elem_t  rd_data;
  count_t sh_prev;

  ust_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CAPACITY)) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign hit         = chk_valid && (rd_data == val_q);
  assign issue_scan  = cmd.scan_step && (scan_idx < count) && !hit;
  assign issue_shift = cmd.shift_step && (sh_idx < count);
  assign sh_prev     = sh_idx - COUNT_BITS'(1);

  // shift moves the entry read last cycle down one place
  always_comb begin
    wr_en   = cmd.append || (cmd.shift_step && sh_pend);
    wr_addr = cmd.append ? count[IDX_BITS-1:0] : sh_wr;
    wr_data = cmd.append ? val_q : rd_data;
    rd_en   = issue_scan || issue_shift;
    rd_addr = cmd.shift_step ? sh_idx[IDX_BITS-1:0] : scan_idx[IDX_BITS-1:0];
  end

  always_comb begin
    st.in_op      = op_t'(opcode);
    st.op         = op_q;
    st.scan_done  = hit || (scan_idx >= count);
    st.hit        = hit;
    st.full       = count >= CAP_COUNT;
    st.shift_done = (sh_idx >= count) && !sh_pend;
    st.out_free   = !out_valid || rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_idx  <= '0;
      chk_valid <= 1'b0;
      sh_idx    <= '0;
      sh_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_idx  <= '0;
        chk_valid <= 1'b0;
      end
      if (cmd.clear) begin
        count <= '0;
      end
      if (cmd.append) begin
        count <= count + COUNT_BITS'(1);
      end
      if (cmd.drop) begin
        count <= count - COUNT_BITS'(1);
      end
      if (cmd.scan_step) begin
        chk_valid <= issue_scan;
        if (issue_scan) begin
          scan_idx <= scan_idx + COUNT_BITS'(1);
        end
      end
      if (cmd.shift_start) begin
        sh_idx  <= COUNT_BITS'(chk_idx) + COUNT_BITS'(1);
        sh_pend <= 1'b0;
      end
      if (cmd.shift_step) begin
        sh_pend <= issue_shift;
        if (issue_shift) begin
          sh_idx <= sh_idx + COUNT_BITS'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(opcode);
      val_q <= normalize(element);
    end
    if (cmd.scan_step) begin
      chk_idx <= scan_idx[IDX_BITS-1:0];
    end
    if (issue_shift) begin
      sh_wr <= sh_prev[IDX_BITS-1:0];
    end
    if (cmd.res_load) begin
      res_was    <= cmd.res_was;
      res_status <= cmd.res_status;
    end
    if (cmd.emit) begin
      rsp.was_member  <= res_was;
      rsp.count_after <= COUNT_OUT_BITS'(count);
      rsp.is_empty    <= count == '0;
      rsp.is_full     <= count == CAP_COUNT;
      rsp.status      <= 2'(res_status);
    end
  end

  assign rsp.valid = out_valid;

endmodule

// File: hw/rtl/ust_ctrl.sv
module ust_ctrl import ust_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ust_stat_t st,
  output ust_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_status = STAT_DONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.in_op == OP_CLEAR) begin
            cmd.clear    = 1'b1;
            cmd.res_load = 1'b1;
            state_next   = ST_FINISH;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_was  = st.hit;
          state_next   = ST_FINISH;
          case (st.op)
            OP_INSERT: begin
              if (st.hit) begin
                cmd.res_status = STAT_NO_CHANGE;
              end else if (st.full) begin
                cmd.res_status = STAT_REJECTED;
              end else begin
                cmd.append = 1'b1;
              end
            end
            OP_DELETE: begin
              if (!st.hit) begin
                cmd.res_status = STAT_NO_CHANGE;
              end else begin
                cmd.shift_start = 1'b1;
                state_next      = ST_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (st.shift_done) begin
          cmd.drop   = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/unordered_set_table_top.sv
// Set of up to CAPACITY distinct values kept as a packed list in one RAM with a
// registered read port. Each request (query, insert, delete, clear) returns one
// result. The list is scanned one entry per cycle through the single read port;
// a delete stops its scan at the hit and then shifts the entries above it down
// one per cycle. One request is in work at a time; a finished result waits in
// the output register while the next request is accepted.
module unordered_set_table_top import ust_pkg::*; (
  input logic       clk,
  input logic       rst,
  ust_req_if.sink   req,
  ust_rsp_if.source rsp
);

  ust_cmd_t  cmd;
  ust_stat_t st;
  logic      ready;

  ust_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (ready),
    .st       (st),
    .cmd      (cmd)
  );

  ust_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .opcode  (req.opcode),
    .element (req.element),
    .cmd     (cmd),
    .st      (st),
    .rsp     (rsp)
  );

  assign req.ready = ready;

endmodule

// File: bench/set_result_checker.sv
`timescale 1ns / 100ps

module set_result_checker import ust_pkg::*; (
  input  logic clk,
  input  logic rst,
  ust_req_if   req,
  ust_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic                      was_member;
    logic [COUNT_OUT_BITS-1:0] count_after;
    logic                      is_empty;
    logic                      is_full;
    stat_t                     status;
  } set_result_t;

  elem_t       members[$];
  set_result_t results_due[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  // update the shadow set for one request and return the result it should produce
  function automatic set_result_t apply_request(op_t op, logic [31:0] raw);
    logic [63:0] wide;
    elem_t       key;
    int          pos;
    set_result_t r;
    wide = {{32{raw[31]}}, raw};
    key = wide[ELEMENT_BITS-1:0];
    pos = -1;
    foreach (members[i]) begin
      if (pos < 0 && members[i] == key) pos = i;
    end
    r.was_member = (pos >= 0);
    r.status = STAT_DONE;
    case (op)
      OP_INSERT: begin
        if (pos >= 0) r.status = STAT_NO_CHANGE;
        else if (members.size() >= CAPACITY) r.status = STAT_REJECTED;
        else members.push_back(key);
      end
      OP_DELETE: begin
        // queue delete keeps the later entries packed in order
        if (pos < 0) r.status = STAT_NO_CHANGE;
        else members.delete(pos);
      end
      OP_CLEAR: begin
        members.delete();
        r.was_member = 1'b0;
      end
      default: ;
    endcase
    r.count_after = COUNT_OUT_BITS'(members.size());
    r.is_empty = (members.size() == 0);
    r.is_full = (members.size() == CAPACITY);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    set_result_t want;
    logic        bad;
    if (rst) begin
      members.delete();
      results_due.delete();
    end else begin
      if (req.valid && req.ready)
        results_due.push_back(apply_request(op_t'(req.opcode), req.element));
      if (rsp.valid && rsp.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request outstanding: was=%0d count=%0d status=%0d",
                     $realtime, rsp.was_member, rsp.count_after, rsp.status);
        end else begin
          want = results_due.pop_front();
          bad = (rsp.was_member !== want.was_member) ||
                (rsp.count_after !== want.count_after) ||
                (rsp.is_empty !== want.is_empty) ||
                (rsp.is_full !== want.is_full) ||
                (rsp.status !== want.status);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected was=%0d count=%0d empty=%0d full=%0d status=%0d",
                       $realtime, want.was_member, want.count_after, want.is_empty,
                       want.is_full, want.status);
              $display("%0t:          actual   was=%0d count=%0d empty=%0d full=%0d status=%0d",
                       $realtime, rsp.was_member, rsp.count_after, rsp.is_empty,
                       rsp.is_full, rsp.status);
            end
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule

// File: bench/unordered_set_table_top_tb.sv
`timescale 1ns / 100ps

module unordered_set_table_top_tb import ust_pkg::*;;

  localparam int POOL_SIZE   = 96;
  localparam int RANDOM_REQS = 800;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * CAPACITY + 12;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_t;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   cycles = 0;
  int   sent = 0;
  bit   calm = 1'b0;
  bit   held_off = 1'b0;

  logic signed [31:0] pool[POOL_SIZE];

  ust_req_if req_ch();
  ust_rsp_if rsp_ch();

  unordered_set_table_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  set_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fails),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("unordered_set_table_top_tb: errors");
      $finish;
    end
  end

  task automatic send_req(op_t op, logic signed [31:0] value);
    while (!calm && $urandom_range(99) < 10) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= op;
    req_ch.element <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic signed [31:0] pick_element();
    if ($urandom_range(99) < 10) return $urandom;
    return pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  function automatic op_t pick_op(mix_t mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      MODE_FILL:  return (r < 85) ? OP_INSERT : (r < 97) ? OP_QUERY : OP_DELETE;
      MODE_DRAIN: return (r < 65) ? OP_DELETE : (r < 90) ? OP_QUERY : OP_INSERT;
      default:    return (r < 40) ? OP_INSERT : (r < 65) ? OP_DELETE :
                         (r < 95) ? OP_QUERY : OP_CLEAR;
    endcase
  endfunction

  // receiver: random back-pressure, plus one long hold-off to back the block up
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && sent >= 550) begin
        held_off = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rst || calm) begin
        rsp_ch.ready <= !rst;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 10);
      end
    end
  end

  initial begin
    int   n;
    int   span;
    mix_t mode;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_QUERY;
    req_ch.element <= '0;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7fff_ffff;
    pool[2] = 32'sh0000_0000;
    pool[3] = -32'sd1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty set corners
    send_req(OP_QUERY,  32'sh0000_0000);
    send_req(OP_DELETE, -32'sd1);
    send_req(OP_CLEAR,  32'sh1234_5678);
    // extremes, a duplicate insert, hit and miss queries
    send_req(OP_INSERT, 32'sh8000_0000);
    send_req(OP_INSERT, 32'sh7fff_ffff);
    send_req(OP_INSERT, 32'sh0000_0000);
    send_req(OP_INSERT, -32'sd1);
    send_req(OP_INSERT, 32'sh7fff_ffff);
    send_req(OP_QUERY,  32'sh8000_0000);
    send_req(OP_QUERY,  32'sh0000_3039);
    // delete from the middle forces a shift of the tail
    send_req(OP_DELETE, 32'sh7fff_ffff);
    send_req(OP_QUERY,  32'sh7fff_ffff);
    send_req(OP_DELETE, -32'sd1);
    send_req(OP_DELETE, 32'sh8000_0000);
    send_req(OP_DELETE, 32'sh5555_5555);
    send_req(OP_INSERT, 32'sh5555_5555);
    send_req(OP_INSERT, 32'shaaaa_aaaa);
    send_req(OP_CLEAR,  32'shffff_ffff);
    send_req(OP_QUERY,  32'sh0000_0000);
    send_req(OP_INSERT, 32'sh0000_0000);

    // random blocks; fill blocks push the set to full and into rejected inserts
    n = 0;
    mode = MODE_FILL;
    while (n < RANDOM_REQS) begin
      span = (mode == MODE_FILL) ? $urandom_range(120, 160) : $urandom_range(60, 150);
      for (int k = 0; k < span && n < RANDOM_REQS; k++) begin
        calm = (n >= 300 && n < 450);
        send_req(pick_op(mode), pick_element());
        n++;
      end
      mode = mix_t'($urandom_range(2));
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("unordered_set_table_top_tb: clean");
    end else begin
      $display("unordered_set_table_top_tb: errors");
    end
    $finish;
  end

endmodule
